// File: rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define AALW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define AALW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/aalw_pkg.sv
// ============================================================================
// aalw_pkg
// Shared types and constants of the ANSI-aware line wrapper.
// ============================================================================
`default_nettype none

package aalw_pkg;

	localparam logic [7:0] ESC_BYTE  = 8'h1B;
	localparam logic [7:0] CSI_BYTE  = 8'h5B;
	localparam logic [7:0] FINAL_LO  = 8'h40;
	localparam logic [7:0] FINAL_HI  = 8'h7E;
	localparam logic [7:0] UTF8_MASK = 8'hC0;
	localparam logic [7:0] UTF8_CONT = 8'h80;

	localparam int COL_W = 10;
	localparam int ROW_W = 8;
	localparam int CFG_DATA_W = 10;

	localparam logic [COL_W-1:0] WRAP_WIDTH_RESET = 10'd80;
	localparam logic [ROW_W-1:0] ROW_LIMIT_RESET  = 8'd24;

	localparam int MAX_RESULTS = 3;
	localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_SEQ  = 2'd0,
		KIND_CONT = 2'd1,
		KIND_VIS  = 2'd2,
		KIND_END  = 2'd3
	} kind_t;

	typedef enum logic [0:0] {
		CFG_WRAP_WIDTH = 1'b0,
		CFG_ROW_LIMIT  = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic                  we;
		cfg_idx_t              index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       has_byte;
		logic       line_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		kind_t            kind;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] column;
		logic             new_row;
		logic [ROW_W-1:0] rows_used;
		logic             last;
	} out_item_t;

	// One result as placed by the front end; rows_used and last are added later.
	typedef struct packed {
		logic [7:0]       out_byte;
		kind_t            kind;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] column;
		logic             new_row;
	} res_t;

	// All results caused by one accepted item, in order.
	typedef struct packed {
		res_t [MAX_RESULTS-1:0] res;
		logic [RES_CNT_W-1:0]   count;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

// File: rtl/aalw_front.sv
// ============================================================================
// aalw_front
// Classifies each item and places its bytes on rows and columns.
// ============================================================================
`default_nettype none

module aalw_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  aalw_pkg::cfg_wr_t    cfg,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  aalw_pkg::in_item_t   in_item,
	input  aalw_pkg::q_status_t  q_status,
	output logic                 push,
	output aalw_pkg::bundle_t    push_bundle
);
	import aalw_pkg::*;

	typedef struct packed {
		logic             esc_pending;
		logic             in_sequence;
		logic [COL_W-1:0] columns_used;
		logic [ROW_W-1:0] current_row;
		logic             stopped;
	} wrap_state_t;

	typedef struct packed {
		wrap_state_t st;
		bundle_t     bd;
	} work_t;

	logic [COL_W-1:0] wrap_width_q;
	logic [ROW_W-1:0] row_limit_q;
	wrap_state_t      state_q;
	work_t            work;
	logic [COL_W-1:0] wid;
	logic [ROW_W-1:0] lim;
	logic             accept;

	function automatic work_t emit_res(work_t w, logic [7:0] b, kind_t k,
			logic [COL_W-1:0] col, logic nr);
		work_t r;
		r = w;
		if (r.bd.count != RES_CNT_W'(MAX_RESULTS)) begin
			r.bd.res[r.bd.count[RES_IDX_W-1:0]] = '{out_byte: b, kind: k,
				row: r.st.current_row, column: col, new_row: nr};
			r.bd.count = r.bd.count + 1'b1;
		end
		return r;
	endfunction

	function automatic work_t visible(work_t w, logic [7:0] b,
			logic [COL_W-1:0] wd, logic [ROW_W-1:0] lm);
		work_t r;
		logic  go;
		logic  nr;
		r  = w;
		go = !r.st.stopped;
		nr = 1'b0;
		if (go && (r.st.columns_used >= wd)) begin
			if (({1'b0, r.st.current_row} + 1'b1) >= {1'b0, lm}) begin
				r.st.stopped = 1'b1;
				go = 1'b0;
			end else begin
				r.st.current_row  = r.st.current_row + 1'b1;
				r.st.columns_used = '0;
				nr = 1'b1;
			end
		end
		if (go) begin
			r = emit_res(r, b, KIND_VIS, r.st.columns_used, nr);
			r.st.columns_used = r.st.columns_used + 1'b1;
		end
		return r;
	endfunction

	function automatic work_t byte_step(work_t w, logic [7:0] b,
			logic [COL_W-1:0] wd, logic [ROW_W-1:0] lm);
		work_t r;
		r = w;
		if (!r.st.stopped) begin
			if (r.st.in_sequence) begin
				r = emit_res(r, b, KIND_SEQ, '0, 1'b0);
				if (b >= FINAL_LO && b <= FINAL_HI) begin
					r.st.in_sequence = 1'b0;
				end
			end else if (b == ESC_BYTE) begin
				r.st.esc_pending = 1'b1;
			end else if ((b & UTF8_MASK) == UTF8_CONT) begin
				r = emit_res(r, b, KIND_CONT, '0, 1'b0);
			end else begin
				r = visible(r, b, wd, lm);
			end
		end
		return r;
	endfunction

	// A zero setting behaves as one.
	assign wid = (wrap_width_q == '0) ? COL_W'(1) : wrap_width_q;
	assign lim = (row_limit_q == '0) ? ROW_W'(1) : row_limit_q;

	always_comb begin
		work    = '0;
		work.st = state_q;
		if (in_item.has_byte) begin
			if (work.st.esc_pending) begin
				work.st.esc_pending = 1'b0;
				if (in_item.in_byte == CSI_BYTE) begin
					if (!work.st.stopped) begin
						work = emit_res(work, ESC_BYTE, KIND_SEQ, '0, 1'b0);
						work = emit_res(work, in_item.in_byte, KIND_SEQ, '0, 1'b0);
						work.st.in_sequence = 1'b1;
					end
				end else begin
					work = visible(work, ESC_BYTE, wid, lim);
					work = byte_step(work, in_item.in_byte, wid, lim);
				end
			end else begin
				work = byte_step(work, in_item.in_byte, wid, lim);
			end
		end
		if (in_item.line_end) begin
			if (work.st.esc_pending) begin
				work.st.esc_pending = 1'b0;
				work = visible(work, ESC_BYTE, wid, lim);
			end
			work    = emit_res(work, 8'h00, KIND_END, '0, 1'b0);
			work.st = '0;
		end
	end

	assign in_ready    = !q_status.full;
	assign accept      = in_valid && in_ready;
	assign push        = accept && (work.bd.count != '0);
	assign push_bundle = work.bd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= '0;
			wrap_width_q <= WRAP_WIDTH_RESET;
			row_limit_q  <= ROW_LIMIT_RESET;
		end else begin
			if (accept) begin
				state_q <= work.st;
			end
			if (cfg.we) begin
				unique case (cfg.index)
					CFG_WRAP_WIDTH: wrap_width_q <= cfg.data[COL_W-1:0];
					CFG_ROW_LIMIT:  row_limit_q  <= cfg.data[ROW_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/aalw_queue.sv
// ============================================================================
// aalw_queue
// Short queue of result bundles between the front and back ends.
// ============================================================================
`default_nettype none

module aalw_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  aalw_pkg::bundle_t    push_bundle,
	input  wire                  pop,
	output aalw_pkg::bundle_t    head,
	output aalw_pkg::q_status_t  status
);
	import aalw_pkg::*;

	bundle_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/aalw_back.sv
// ============================================================================
// aalw_back
// Unpacks queued bundles into single result items behind an output register.
// ============================================================================
`default_nettype none

module aalw_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  aalw_pkg::q_status_t  q_status,
	input  aalw_pkg::bundle_t    head,
	output logic                 pop,
	output logic                 out_valid,
	input  wire                  out_ready,
	output aalw_pkg::out_item_t  out_item
);
	import aalw_pkg::*;

	logic [RES_IDX_W-1:0] idx_q;
	logic                 out_valid_q;
	out_item_t            out_item_q;
	res_t                 cur;
	logic                 is_last;
	logic                 take;

	assign cur     = head.res[idx_q];
	assign is_last = (idx_q == RES_IDX_W'(head.count - 1'b1));
	assign take    = !q_status.empty && (!out_valid_q || out_ready);
	assign pop     = take && is_last;

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk) begin
		if (take) begin
			out_item_q.out_byte  <= cur.out_byte;
			out_item_q.kind      <= cur.kind;
			out_item_q.row       <= cur.row;
			out_item_q.column    <= cur.column;
			out_item_q.new_row   <= cur.new_row;
			out_item_q.rows_used <= cur.row + 1'b1;
			out_item_q.last      <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? '0 : idx_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/ansi_aware_line_wrapper.sv
// ============================================================================
// ansi_aware_line_wrapper
// Wraps the bytes of a text line into rows, skipping ESC '[' sequences and
// UTF-8 continuation bytes when counting columns.
// ============================================================================
//
// Channel  Direction  Handshake             Payload
// -------  ---------  --------------------  ---------------------------------
// in       input      in_valid / in_ready   in_item  (byte, has_byte, line_end)
// out      output     out_valid / out_ready out_item (byte, kind, row, column,
//                                                     new_row, rows_used, last)
// cfg      input      cfg_wr_en             cfg_index, cfg_wdata
//
// An item is accepted whenever the bundle queue has room; its bundle is
// written to the queue, then its results pass through the output register.
// Results leave at one per cycle while out_ready is high, so an item causing
// two or three results (a held ESC, an ESC '[' pair or a line end) yields
// that many output items; the four-entry bundle queue absorbs these bursts.
// Reset restores the width to 80 and the row limit to 24 and clears all
// line state; no clearing pass is needed. A stalled output fills the queue
// and only then drops in_ready.
// ============================================================================
`default_nettype none

`include "assert_macros.svh"

module ansi_aware_line_wrapper (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  aalw_pkg::in_item_t                    in_item,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output aalw_pkg::out_item_t                   out_item,
	input  wire                                   cfg_wr_en,
	input  aalw_pkg::cfg_idx_t                    cfg_index,
	input  wire [aalw_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
	import aalw_pkg::*;

	cfg_wr_t   cfg;
	q_status_t q_status;
	logic      push;
	bundle_t   push_bundle;
	logic      pop;
	bundle_t   head;

	// The configuration write travels to the front end as one group.
	assign cfg.we    = cfg_wr_en;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_wdata;

	// The front end keeps all line state: it resolves a held ESC against the
	// next byte, tracks whether a control sequence is open, and places each
	// visible character on a row and column. Every result an item causes is
	// gathered into one bundle.
	aalw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.q_status    (q_status),
		.push        (push),
		.push_bundle (push_bundle)
	);

	// Bundles wait here, so the input keeps flowing while the output stalls, until the queue is full.
	aalw_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_bundle (push_bundle),
		.pop         (pop),
		.head        (head),
		.status      (q_status)
	);

	// The back end hands out one result per cycle while out_ready is high and
	// marks the last one of each bundle.
	aalw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// The front end never writes into a full queue.
	`AALW_ASSERT_NOW(a_no_push_full, push, !q_status.full, "push into full queue")
	// A pushed bundle is there to be read in the next cycle.
	`AALW_ASSERT_NEXT(a_push_fills, push, !q_status.empty, "queue empty after push")
	// The line end result always closes its item.
	`AALW_ASSERT_NOW(a_end_is_last, out_valid && (out_item.kind == KIND_END),
		out_item.last, "line end result not marked last")
	// A wrap always puts the character in the first column.
	`AALW_ASSERT_NOW(a_wrap_col0, out_valid && out_item.new_row,
		(out_item.kind == KIND_VIS) && (out_item.column == '0),
		"wrap without visible character at column zero")

endmodule

`default_nettype wire
